/* sv/scrolling_seven_segment_marquee_macros.svh */
// Assertion macros shared by the marquee RTL.
`ifndef SCROLLING_SEVEN_SEGMENT_MARQUEE_MACROS_SVH
`define SCROLLING_SEVEN_SEGMENT_MARQUEE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SSM_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("marquee check failed");

// Next-cycle implication, disabled while reset is high.
`define SSM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("marquee check failed");

`endif

/* sv/ssm_pkg.sv */
// Shared types, constants and the letter segment table of the marquee.
`timescale 1ns / 1ps
`default_nettype none
package ssm_pkg;

   localparam int NUM_DIGITS_DEFAULT = 4;
   localparam int MAX_CHARS_DEFAULT  = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] REG_TEXT_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TEXT_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LENGTH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TICKS     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_REVERSE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ANODE     = 3'd5;

   localparam logic [4:0]  LENGTH_RESET = 5'd4;
   localparam logic [15:0] TICKS_RESET  = 16'd500;

   localparam int DIGIT_LINES = 4;
   localparam int SEG_W       = 7;

   typedef struct packed {
      logic [127:0] text_chars;
      logic [4:0]   text_length;
      logic [15:0]  scroll_ticks;
      logic         scroll_reverse;
      logic         common_anode;
   } cfg_type;

   // Segments a..g (a in bit 6) for lowercase letters except q, w and x; every other code is blank.
   function automatic logic [SEG_W-1:0] letter_segments(input logic [7:0] code);
      logic [SEG_W-1:0] segs;
      case (code)
         8'h61:   segs = 7'h77;
         8'h62:   segs = 7'h1F;
         8'h63:   segs = 7'h0D;
         8'h64:   segs = 7'h3D;
         8'h65:   segs = 7'h4F;
         8'h66:   segs = 7'h47;
         8'h67:   segs = 7'h5F;
         8'h68:   segs = 7'h17;
         8'h69:   segs = 7'h06;
         8'h6A:   segs = 7'h3C;
         8'h6B:   segs = 7'h07;
         8'h6C:   segs = 7'h0E;
         8'h6D:   segs = 7'h76;
         8'h6E:   segs = 7'h15;
         8'h6F:   segs = 7'h1D;
         8'h70:   segs = 7'h67;
         8'h72:   segs = 7'h05;
         8'h73:   segs = 7'h5B;
         8'h74:   segs = 7'h70;
         8'h75:   segs = 7'h1C;
         8'h76:   segs = 7'h23;
         8'h79:   segs = 7'h33;
         8'h7A:   segs = 7'h6D;
         default: segs = 7'h00;
      endcase
      return segs;
   endfunction

endpackage
`default_nettype wire

/* sv/ssm_csr.sv */
// Configuration register file of the marquee.
`timescale 1ns / 1ps
`default_nettype none
module ssm_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [ssm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ssm_pkg::CSR_DATA_W-1:0]  csr_data,
   output ssm_pkg::cfg_type                    cfg
);
   import ssm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_TEXT_LOW:  cfg_in.text_chars[63:0]   = csr_data;
            REG_TEXT_HIGH: cfg_in.text_chars[127:64] = csr_data;
            REG_LENGTH:    cfg_in.text_length        = csr_data[4:0];
            REG_TICKS:     cfg_in.scroll_ticks       = csr_data[15:0];
            REG_REVERSE:   cfg_in.scroll_reverse     = csr_data[0];
            REG_ANODE:     cfg_in.common_anode       = csr_data[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.text_chars     <= '0;
         cfg_ff.text_length    <= LENGTH_RESET;
         cfg_ff.scroll_ticks   <= TICKS_RESET;
         cfg_ff.scroll_reverse <= 1'b0;
         cfg_ff.common_anode   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

/* sv/ssm_engine.sv */
// Scroll state, character lookup and drive levels for one refresh tick.
`timescale 1ns / 1ps
`default_nettype none
module ssm_engine #(
   parameter int NUM_DIGITS = ssm_pkg::NUM_DIGITS_DEFAULT,
   parameter int MAX_CHARS  = ssm_pkg::MAX_CHARS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic                              reset_level,
   input  wire ssm_pkg::cfg_type                  cfg,
   output logic [ssm_pkg::DIGIT_LINES-1:0]        digit_drive,
   output logic [ssm_pkg::SEG_W-1:0]              segment_drive
);
   import ssm_pkg::*;

   localparam int DW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam logic signed [5:0] NUM_S = 6'(NUM_DIGITS);
   localparam logic [4:0] LEN_MIN = 5'(NUM_DIGITS);
   localparam logic [4:0] LEN_MAX = 5'(MAX_CHARS);
   localparam logic [DW-1:0] DIGIT_LAST = DW'(NUM_DIGITS - 1);

   logic signed [5:0] position_ff, position_in;
   logic [DW-1:0]     digit_ff, digit_in;
   logic [15:0]       tick_ff, tick_in;

   logic [4:0]        len;
   logic signed [5:0] len_s, start, cur, sum, wrapped, stepped;
   logic [3:0]        char_idx;
   logic [7:0]        char_code;
   logic [15:0]       limit;
   logic [16:0]       tick_inc;
   logic [DIGIT_LINES-1:0] digits_on;
   logic [SEG_W-1:0]  segs;

   always_comb begin
      if (cfg.text_length < LEN_MIN) begin
         len = LEN_MIN;
      end else if (cfg.text_length > LEN_MAX) begin
         len = LEN_MAX;
      end else begin
         len = cfg.text_length;
      end
   end

   assign len_s = signed'({1'b0, len});
   assign start = cfg.scroll_reverse ? (len_s - 6'sd1 - NUM_S) : 6'sd0;

   // Reload the start when the held position no longer fits the length.
   assign cur = ((position_ff < -NUM_S) || (position_ff >= len_s)) ? start : position_ff;

   assign sum = cur + signed'({{(6 - DW){1'b0}}, digit_ff});

   always_comb begin
      if (sum < 6'sd0) begin
         wrapped = sum + len_s;
      end else if (sum >= len_s) begin
         wrapped = sum - len_s;
      end else begin
         wrapped = sum;
      end
   end

   assign char_idx  = wrapped[3:0];
   assign char_code = cfg.text_chars[{char_idx, 3'b000} +: 8];

   always_comb begin
      for (int k = 0; k < DIGIT_LINES; k++) begin
         digits_on[k] = ({{(32 - DW){1'b0}}, digit_ff} == 32'(k));
      end
   end

   assign limit    = (cfg.scroll_ticks == 16'd0) ? 16'd1 : cfg.scroll_ticks;
   assign tick_inc = {1'b0, tick_ff} + 17'd1;
   assign stepped  = cfg.scroll_reverse ? (cur - 6'sd1) : (cur + 6'sd1);

   always_comb begin
      position_in = position_ff;
      digit_in    = digit_ff;
      tick_in     = tick_ff;
      segs        = '0;
      digit_drive = cfg.common_anode ? '0 : '1;
      if (advance) begin
         if (reset_level) begin
            position_in = start;
            digit_in    = '0;
            tick_in     = '0;
         end else begin
            segs        = letter_segments(char_code);
            digit_drive = cfg.common_anode ? digits_on : ~digits_on;
            digit_in    = (digit_ff == DIGIT_LAST) ? '0 : digit_ff + DW'(1);
            position_in = cur;
            tick_in     = tick_inc[15:0];
            if (tick_inc >= {1'b0, limit}) begin
               tick_in = '0;
               if ((stepped < -NUM_S) || (stepped >= len_s)) begin
                  position_in = start;
               end else begin
                  position_in = stepped;
               end
            end
         end
      end
      segment_drive = cfg.common_anode ? ~segs : segs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         digit_ff    <= '0;
         tick_ff     <= '0;
      end else begin
         position_ff <= position_in;
         digit_ff    <= digit_in;
         tick_ff     <= tick_in;
      end
   end

endmodule
`default_nettype wire

/* sv/scrolling_seven_segment_marquee.sv */
// Scrolling seven-segment marquee: top level with input and result registers.
// Usage:
// - req_ carries one refresh tick per transaction with the reset button level;
//   rsp_ returns one transaction per tick with the digit and segment drives.
// - csr_ writes registers 0..5 (text low/high, length, scroll ticks, reverse,
//   common anode); csr_ready is always high. Write only while the block is idle.
// - A tick accepted into the input register is evaluated, and its result is
//   registered into the result register on rsp_ once that register is free.
// - Throughput is one tick per cycle while rsp_stall is low: the position, digit and tick counter
//   update in the single evaluation step between the two registers.
// - While rsp_stall holds a waiting result, one more tick is taken into the
//   input register; req_stall then rises until the result leaves.
// - reset (synchronous) empties both registers, restores the registers to
//   their reset values and puts the scroll at position 0, digit 0.
// - A tick with the button pressed returns to the start position and shows
//   all digits deselected and all segments dark.
`timescale 1ns / 1ps
`default_nettype none
module scrolling_seven_segment_marquee #(
   parameter int NUM_DIGITS = ssm_pkg::NUM_DIGITS_DEFAULT,
   parameter int MAX_CHARS  = ssm_pkg::MAX_CHARS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_reset_level,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [ssm_pkg::DIGIT_LINES-1:0]       rsp_digit_drive,
   output logic [ssm_pkg::SEG_W-1:0]             rsp_segment_drive,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ssm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ssm_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ssm_pkg::*;
   `include "scrolling_seven_segment_marquee_macros.svh"

   cfg_type cfg;

   logic s1_valid_ff, s1_valid_in;
   logic s1_level_ff, s1_level_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_LINES-1:0] rsp_digit_ff;
   logic [SEG_W-1:0]       rsp_segment_ff;
   logic [DIGIT_LINES-1:0] eng_digit;
   logic [SEG_W-1:0]       eng_segment;
   logic advance;

   ssm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ssm_engine #(
      .NUM_DIGITS (NUM_DIGITS),
      .MAX_CHARS  (MAX_CHARS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .reset_level   (s1_level_ff),
      .cfg           (cfg),
      .digit_drive   (eng_digit),
      .segment_drive (eng_segment)
   );

   // Move the held tick on when the result register is empty or being drained.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_level_in = s1_level_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_level_in = req_reset_level;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_level_ff <= s1_level_in;
      if (advance) begin
         rsp_digit_ff   <= eng_digit;
         rsp_segment_ff <= eng_segment;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_digit_drive   = rsp_digit_ff;
   assign rsp_segment_drive = rsp_segment_ff;

   `SSM_ASSERT_NOW(a_stall_needs_full_output, clock, reset, req_stall, rsp_valid_ff && rsp_stall)
   `SSM_ASSERT_NEXT(a_advance_fills_output, clock, reset, advance, rsp_valid_ff)
   `SSM_ASSERT_NEXT(a_button_blanks, clock, reset, advance && s1_level_ff,
      (rsp_segment_ff == ($past(cfg.common_anode) ? 7'h7F : 7'h00)) &&
      (rsp_digit_ff == ($past(cfg.common_anode) ? 4'h0 : 4'hF)))
   `SSM_ASSERT_NEXT(a_output_holds, clock, reset, rsp_valid_ff && rsp_stall,
      $stable(rsp_digit_ff) && $stable(rsp_segment_ff))

endmodule
`default_nettype wire
